// ===== design/crcl_pkg.sv =====
// Package for the CRC log record writer: field widths, default slot geometry,
// result kind codes and the CRC-16 byte update. No dependencies.
package crcl_pkg;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned ADDR_W = 11;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned CRC_W  = 16;
  localparam int unsigned POS_W  = 6;

  localparam int unsigned SLOT_COUNT_DEF = 32;
  localparam int unsigned SLOT_BYTES_DEF = 64;
  localparam int unsigned TEXT_LIMIT     = 61;

  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;

  localparam logic KIND_STORE  = 1'b0;
  localparam logic KIND_REJECT = 1'b1;

  // CRC-16, poly 0x1021, MSB first, one byte per call
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                input logic [CHAR_W-1:0] c);
    logic [7:0] x;
    x = crc[15:8] ^ c;
    x = x ^ {4'd0, x[7:4]};
    return {crc[7:0], 8'd0} ^ {x[3:0], 12'd0} ^ {3'd0, x, 5'd0} ^ {8'd0, x};
  endfunction

endpackage

// ===== design/crcl_char_if.sv =====
// Character input channel: valid/ready handshake carrying one message character.
// Depends on crcl_pkg.
interface crcl_char_if;
  logic                        valid;
  logic                        ready;
  logic [crcl_pkg::CHAR_W-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

// ===== design/crcl_rec_if.sv =====
// Record write channel: valid/ready handshake carrying one store write or reject beat.
// Depends on crcl_pkg.
interface crcl_rec_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [crcl_pkg::ADDR_W-1:0] address;
  logic [crcl_pkg::DATA_W-1:0] data;
  logic                        last_of_run;

  modport source (output valid, output kind, output address, output data,
                  output last_of_run, input ready);
  modport sink   (input valid, input kind, input address, input data,
                  input last_of_run, output ready);
endinterface

// ===== design/crc_log_record_writer.sv =====
// Log record writer. A character gives one store beat; a terminator gives
// three beats (zero, CRC high, CRC low); an empty message gives one reject
// beat; characters past the record limit give nothing. When a message starts
// with the log full, SLOT_COUNT erase beats come first, one per cycle while the
// output is not stalled. Input is held off while an item has beats left to send;
// the single job register feeding the output register sets this pacing. Depends on
// crcl_pkg, crcl_char_if and crcl_rec_if.
module crc_log_record_writer #(
  parameter int unsigned SLOT_COUNT = crcl_pkg::SLOT_COUNT_DEF,
  parameter int unsigned SLOT_BYTES = crcl_pkg::SLOT_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  crcl_char_if.sink   chars,
  crcl_rec_if.source  records
);

  localparam int unsigned ADDR_W   = crcl_pkg::ADDR_W;
  localparam int unsigned DATA_W   = crcl_pkg::DATA_W;
  localparam int unsigned CHAR_W   = crcl_pkg::CHAR_W;
  localparam int unsigned CRC_W    = crcl_pkg::CRC_W;
  localparam int unsigned POS_W    = crcl_pkg::POS_W;
  localparam int unsigned TEXT_MAX = ((SLOT_BYTES - 3) < crcl_pkg::TEXT_LIMIT) ?
                                     (SLOT_BYTES - 3) : crcl_pkg::TEXT_LIMIT;
  localparam int unsigned USED_W   = $clog2(SLOT_COUNT + 1);
  localparam int unsigned IDX_W    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned SB_W     = $clog2(SLOT_BYTES + 1);
  localparam int unsigned BASE_W   = USED_W + SB_W;
  localparam int unsigned ERA_W    = IDX_W + SB_W;
  localparam logic [1:0]  TERM_LAST = 2'd2;

  typedef enum logic [1:0] {
    OP_CHAR,
    OP_REJECT,
    OP_TERM
  } op_t;

  // message state
  logic [USED_W-1:0] slots_used;
  logic [POS_W-1:0]  char_index;
  logic [CRC_W-1:0]  running_crc;

  // job register: beats still owed for the last accepted item
  logic              job_valid;
  logic              erase_pend;
  logic [IDX_W-1:0]  erase_idx;
  op_t               op;
  logic [1:0]        term_step;
  logic [ADDR_W-1:0] job_addr;
  logic [CHAR_W-1:0] job_char;
  logic [CRC_W-1:0]  job_crc;

  // output register
  logic              out_valid;
  logic              out_kind;
  logic [ADDR_W-1:0] out_addr;
  logic [DATA_W-1:0] out_data;
  logic              out_last;

  logic              out_free, emit_fire, job_last, in_ready, accept;
  logic              need_erase, is_end, in_text, has_result;
  logic [USED_W-1:0] used_eff;
  logic [BASE_W-1:0] base_full;
  logic [ADDR_W-1:0] rec_addr;
  logic [ERA_W-1:0]  erase_full;
  op_t               op_new;

  logic              emit_kind;
  logic [ADDR_W-1:0] emit_addr;
  logic [DATA_W-1:0] emit_data;
  logic              emit_last;

  assign out_free  = !out_valid || records.ready;
  assign emit_fire = job_valid && out_free;
  assign job_last  = !erase_pend && (op != OP_TERM || term_step == TERM_LAST);
  assign in_ready  = !job_valid || (emit_fire && job_last);
  assign accept    = chars.valid && in_ready;
  assign chars.ready = in_ready;

  assign need_erase = (char_index == '0) && (slots_used >= USED_W'(SLOT_COUNT));
  assign used_eff   = need_erase ? '0 : slots_used;
  assign base_full  = BASE_W'(used_eff) * BASE_W'(SLOT_BYTES);
  assign rec_addr   = ADDR_W'(base_full) + ADDR_W'(char_index);
  assign is_end     = (chars.char_code == '0);
  assign in_text    = (char_index < POS_W'(TEXT_MAX));
  assign has_result = is_end || in_text;
  assign erase_full = ERA_W'(erase_idx) * ERA_W'(SLOT_BYTES);

  always_comb begin
    if (!is_end) begin
      op_new = OP_CHAR;
    end else if (char_index == '0) begin
      op_new = OP_REJECT;
    end else begin
      op_new = OP_TERM;
    end
  end

  always_comb begin
    emit_kind = crcl_pkg::KIND_STORE;
    emit_addr = '0;
    emit_data = '0;
    emit_last = 1'b1;
    if (erase_pend) begin
      emit_addr = ADDR_W'(erase_full);
      emit_last = 1'b0;
    end else begin
      case (op)
        OP_CHAR: begin
          emit_addr = job_addr;
          emit_data = job_char;
        end
        OP_REJECT: begin
          emit_kind = crcl_pkg::KIND_REJECT;
        end
        OP_TERM: begin
          emit_addr = job_addr + ADDR_W'(term_step);
          emit_last = (term_step == TERM_LAST);
          case (term_step)
            2'd1:    emit_data = job_crc[15:8];
            2'd2:    emit_data = job_crc[7:0];
            default: emit_data = '0;
          endcase
        end
        default: begin
          emit_last = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_used  <= '0;
      char_index  <= '0;
      running_crc <= crcl_pkg::CRC_INIT;
      job_valid   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (accept && has_result) begin
        if (op_new == OP_CHAR) begin
          slots_used  <= used_eff;
          running_crc <= crcl_pkg::crc_byte(running_crc, chars.char_code);
          char_index  <= char_index + POS_W'(1);
        end else if (op_new == OP_REJECT) begin
          slots_used  <= used_eff;
          running_crc <= crcl_pkg::CRC_INIT;
        end else begin
          slots_used  <= used_eff + USED_W'(1);
          char_index  <= '0;
          running_crc <= crcl_pkg::CRC_INIT;
        end
      end

      // a new job only lands when no job is pending or the previous one sends its last beat
      if (accept && has_result) begin
        job_valid  <= 1'b1;
        erase_pend <= need_erase;
        erase_idx  <= '0;
        op         <= op_new;
        term_step  <= '0;
        job_addr   <= rec_addr;
        job_char   <= chars.char_code;
        job_crc    <= running_crc;
      end else if (emit_fire) begin
        if (erase_pend) begin
          if (erase_idx == IDX_W'(SLOT_COUNT - 1)) begin
            erase_pend <= 1'b0;
          end else begin
            erase_idx <= erase_idx + IDX_W'(1);
          end
        end else if (op == OP_TERM && term_step != TERM_LAST) begin
          term_step <= term_step + 2'd1;
        end else begin
          job_valid <= 1'b0;
        end
      end

      if (out_free) begin
        out_valid <= emit_fire;
        out_kind  <= emit_kind;
        out_addr  <= emit_addr;
        out_data  <= emit_data;
        out_last  <= emit_last;
      end
    end
  end

  assign records.valid       = out_valid;
  assign records.kind        = out_kind;
  assign records.address     = out_addr;
  assign records.data        = out_data;
  assign records.last_of_run = out_last;

endmodule

// ===== design/crcl_checker.sv =====
// Port-level checks for crc_log_record_writer, attached by bind.
// Depends on crcl_pkg and the top level's interface ports.
module crcl_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        rec_valid,
  input logic                        rec_ready,
  input logic                        rec_kind,
  input logic [crcl_pkg::ADDR_W-1:0] rec_address,
  input logic [crcl_pkg::DATA_W-1:0] rec_data,
  input logic                        rec_last
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    rec_valid && !rec_ready |=> rec_valid && $stable(rec_kind) && $stable(rec_address)
                                && $stable(rec_data) && $stable(rec_last))
    else $error("output beat changed while stalled");

  a_reject_form: assert property (@(posedge clk) disable iff (rst)
    rec_valid && rec_kind == crcl_pkg::KIND_REJECT
      |-> rec_last && rec_address == '0 && rec_data == '0)
    else $error("reject beat malformed");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rec_valid)
    else $error("output valid after reset");

endmodule

bind crc_log_record_writer crcl_checker u_crcl_checker (
  .clk         (clk),
  .rst         (rst),
  .rec_valid   (records.valid),
  .rec_ready   (records.ready),
  .rec_kind    (records.kind),
  .rec_address (records.address),
  .rec_data    (records.data),
  .rec_last    (records.last_of_run)
);
